### src/vfbm_pkg.sv
// ---------------------------------------------------------------------------
// vfbm_pkg
// Shared types and constants of the fractal value noise core.
// ---------------------------------------------------------------------------
`default_nettype none
package vfbm_pkg;

    localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;
    localparam logic [63:0] SEED_STEP  = 64'd7919;
    localparam int          Q24_BITS   = 24;
    localparam logic [25:0] EASE_THREE = 26'd50331648;
    localparam int          IN_W       = 136;
    localparam int          OUT_W      = 24;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EASE_A,
        S_EASE_AW,
        S_EASE_B,
        S_EASE_BW,
        S_HASH_A,
        S_HASH_AW,
        S_HASH_B,
        S_HASH_BW,
        S_LERP,
        S_LERP_W,
        S_ACCUM,
        S_DIV,
        S_DIV_W,
        S_PUSH
    } t_state;

endpackage
`default_nettype wire

### src/vfbm_mul64.sv
// ---------------------------------------------------------------------------
// vfbm_mul64
// Shared multiplier: low 64 bits of a 64x64 product from three 32x32 parts.
// ---------------------------------------------------------------------------
`default_nettype none
module vfbm_mul64 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_done,
    output logic [63:0]      o_p
);
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [2:0]  r_ph;
    logic [63:0] r_pp;
    logic [63:0] r_p;
    logic        r_done;
    logic [31:0] op_a;
    logic [31:0] op_b;

    assign op_a = (r_ph == 3'd3) ? r_a[63:32] : r_a[31:0];
    assign op_b = (r_ph == 3'd2) ? r_b[63:32] : r_b[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_ph == 3'd4);
            if (i_start) begin
                r_ph <= 3'd1;
            end else if (r_ph != 3'd0) begin
                r_ph <= (r_ph == 3'd4) ? 3'd0 : r_ph + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        r_pp <= 64'(op_a) * 64'(op_b);
        case (r_ph)
            3'd2:    r_p <= r_pp;
            3'd3:    r_p <= r_p + {r_pp[31:0], 32'd0};
            3'd4:    r_p <= r_p + {r_pp[31:0], 32'd0};
            default: r_p <= r_p;
        endcase
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule
`default_nettype wire

### src/vfbm_div.sv
// ---------------------------------------------------------------------------
// vfbm_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module vfbm_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 8,
    parameter int Q_W   = 24
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [Q_W-1:0]        o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [Q_W-1:0]   r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   sh;
    logic [DEN_W:0]   diff;
    logic             take;

    assign sh   = {r_rem, r_num[NUM_W-1]};
    assign diff = sh - {1'b0, r_den};
    assign take = (sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_cnt <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= take ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
            r_q   <= {r_q[Q_W-2:0], take};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule
`default_nettype wire

### src/value_noise_fbm_core.sv
// ---------------------------------------------------------------------------
// value_noise_fbm_core
// Fractal 2D value noise: splitmix64 lattice hashes, smoothstep blending.
// ---------------------------------------------------------------------------
// Input channel s: one request carries seed, point x/y (signed fixed point)
// and an octave count, clamped to 1..MAX_OCTAVES. Output channel m carries
// the Q0.24 noise value.
// Each octave runs 23 multiplies on the shared 64-bit multiplier (four for
// the smoothstep weights, sixteen for eight splitmix64 finalizers, three for
// the bilinear blend); a normalizing divide then turns the weighted octave
// sum into the result. Requests are handled one at a time.
// o_s_tready is high only between requests. A finished result sits in the
// output register; the next request is accepted while it waits, and the core
// holds its result before the output if the receiver still stalls.
// Reset clears the sequencer and the output valid.
// ---------------------------------------------------------------------------
`default_nettype none
module value_noise_fbm_core #(
    parameter int MAX_OCTAVES     = 8,
    parameter int COORD_FRAC_BITS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_tvalid,
    output logic                            o_s_tready,
    // noise_seed[63:0], point_x[95:64], point_y[127:96], octave_count[131:128]
    input  wire logic [vfbm_pkg::IN_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  wire logic                       i_m_tready,
    // noise_value[23:0]
    output logic [vfbm_pkg::OUT_W-1:0]      o_m_tdata
);
    import vfbm_pkg::*;

    localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
    localparam int ACC_W = Q24_BITS + MAX_OCTAVES;
    localparam int F     = COORD_FRAC_BITS;

    t_state r_state;
    t_state n_state;

    logic [63:0]      r_seed;
    logic [63:0]      r_px;
    logic [63:0]      r_py;
    logic [OCT_W-1:0] r_n;
    logic [OCT_W-1:0] r_oct;
    logic [ACC_W-1:0] r_acc;
    logic             r_axis;
    logic [23:0]      r_t2;
    logic [23:0]      r_sx;
    logic [23:0]      r_sy;
    logic [2:0]       r_hidx;
    logic [63:0]      r_hv;
    logic [63:0]      r_fx0;
    logic [63:0]      r_fx1;
    logic [63:0]      r_fy0;
    logic [63:0]      r_fy1;
    logic [23:0]      r_c00;
    logic [23:0]      r_c10;
    logic [23:0]      r_c01;
    logic [23:0]      r_c11;
    logic [1:0]       r_lidx;
    logic [23:0]      r_up;
    logic [23:0]      r_lo;
    logic [23:0]      r_val;
    logic [23:0]      r_q;
    logic             r_ovalid;
    logic [23:0]      r_odata;

    logic             mul_start;
    logic [63:0]      mul_a;
    logic [63:0]      mul_b;
    logic             mul_done;
    logic [63:0]      mul_p;
    logic             div_start;
    logic             div_done;
    logic [23:0]      div_quo;

    logic             s_acc;
    logic [3:0]       cnt_in;
    logic [OCT_W-1:0] n_clamp;
    logic [63:0]      cur_p;
    logic [23:0]      t_frac;
    logic [25:0]      ease_k;
    logic [63:0]      x0;
    logic [63:0]      y0;
    logic [63:0]      hin;
    logic [63:0]      hres;
    logic [23:0]      la;
    logic [23:0]      lb;
    logic [23:0]      ls;
    logic             lge;
    logic [23:0]      ldiff;
    logic [23:0]      lres;
    logic             last_oct;
    logic [OCT_W-1:0] wshift;
    logic [OCT_W-1:0] tshift;
    logic [MAX_OCTAVES:0] tot_full;

    assign s_acc  = i_s_tvalid && o_s_tready;
    assign cnt_in = i_s_tdata[131:128];

    always_comb begin
        if (cnt_in == 4'd0) begin
            n_clamp = OCT_W'(1);
        end else if (32'(cnt_in) > MAX_OCTAVES) begin
            n_clamp = OCT_W'(MAX_OCTAVES);
        end else begin
            n_clamp = OCT_W'(cnt_in);
        end
    end

    assign cur_p  = r_axis ? r_py : r_px;
    assign t_frac = 24'(cur_p[F-1:0]) << (Q24_BITS - F);
    assign ease_k = EASE_THREE - {1'b0, t_frac, 1'b0};
    assign x0     = 64'($signed(r_px) >>> F);
    assign y0     = 64'($signed(r_py) >>> F);
    assign hres   = mul_p ^ (mul_p >> 31);

    always_comb begin
        case (r_hidx)
            3'd0:    hin = x0;
            3'd1:    hin = x0 + 64'd1;
            3'd2:    hin = y0;
            3'd3:    hin = y0 + 64'd1;
            3'd4:    hin = r_seed ^ r_fx0 ^ (r_fy0 << 1);
            3'd5:    hin = r_seed ^ r_fx1 ^ (r_fy0 << 1);
            3'd6:    hin = r_seed ^ r_fx0 ^ (r_fy1 << 1);
            default: hin = r_seed ^ r_fx1 ^ (r_fy1 << 1);
        endcase
    end

    always_comb begin
        case (r_lidx)
            2'd0: begin
                la = r_c00;
                lb = r_c10;
                ls = r_sx;
            end
            2'd1: begin
                la = r_c01;
                lb = r_c11;
                ls = r_sx;
            end
            default: begin
                la = r_up;
                lb = r_lo;
                ls = r_sy;
            end
        endcase
    end

    assign lge   = (lb >= la);
    assign ldiff = lge ? (lb - la) : (la - lb);
    assign lres  = lge ? (la + mul_p[47:24]) : (la - mul_p[47:24]);

    assign last_oct = (OCT_W'(r_oct + OCT_W'(1)) == r_n);
    assign wshift   = OCT_W'(MAX_OCTAVES - 1) - r_oct;
    assign tshift   = OCT_W'(MAX_OCTAVES) - r_n;
    assign tot_full = ((MAX_OCTAVES+1)'(1) << MAX_OCTAVES)
                    - ((MAX_OCTAVES+1)'(1) << tshift);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_s_tvalid) n_state = S_EASE_A;
            S_EASE_A:  n_state = S_EASE_AW;
            S_EASE_AW: if (mul_done) n_state = S_EASE_B;
            S_EASE_B:  n_state = S_EASE_BW;
            S_EASE_BW: if (mul_done) n_state = r_axis ? S_HASH_A : S_EASE_A;
            S_HASH_A:  n_state = S_HASH_AW;
            S_HASH_AW: if (mul_done) n_state = S_HASH_B;
            S_HASH_B:  n_state = S_HASH_BW;
            S_HASH_BW: if (mul_done) n_state = (r_hidx == 3'd7) ? S_LERP : S_HASH_A;
            S_LERP:    n_state = S_LERP_W;
            S_LERP_W:  if (mul_done) n_state = (r_lidx == 2'd2) ? S_ACCUM : S_LERP;
            S_ACCUM:   n_state = last_oct ? S_DIV : S_EASE_A;
            S_DIV:     n_state = S_DIV_W;
            S_DIV_W:   if (div_done) n_state = S_PUSH;
            S_PUSH:    if (!r_ovalid || i_m_tready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        case (r_state)
            S_EASE_A: begin
                mul_start = 1'b1;
                mul_a     = 64'(t_frac);
                mul_b     = 64'(t_frac);
            end
            S_EASE_B: begin
                mul_start = 1'b1;
                mul_a     = 64'(r_t2);
                mul_b     = 64'(ease_k);
            end
            S_HASH_A: begin
                mul_start = 1'b1;
                mul_a     = hin ^ (hin >> 30);
                mul_b     = MIX_MUL_A;
            end
            S_HASH_B: begin
                mul_start = 1'b1;
                mul_a     = r_hv;
                mul_b     = MIX_MUL_B;
            end
            S_LERP: begin
                mul_start = 1'b1;
                mul_a     = 64'(ldiff);
                mul_b     = 64'(ls);
            end
            S_DIV: begin
                div_start = 1'b1;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PUSH && (!r_ovalid || i_m_tready)) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    r_seed <= i_s_tdata[63:0];
                    r_px   <= {{32{i_s_tdata[95]}}, i_s_tdata[95:64]};
                    r_py   <= {{32{i_s_tdata[127]}}, i_s_tdata[127:96]};
                    r_n    <= n_clamp;
                    r_oct  <= '0;
                    r_acc  <= '0;
                    r_axis <= 1'b0;
                end
            end
            S_EASE_AW: begin
                if (mul_done) r_t2 <= mul_p[47:24];
            end
            S_EASE_BW: begin
                if (mul_done) begin
                    if (r_axis) r_sy <= mul_p[47:24];
                    else        r_sx <= mul_p[47:24];
                    r_axis <= ~r_axis;
                    r_hidx <= 3'd0;
                end
            end
            S_HASH_AW: begin
                if (mul_done) r_hv <= mul_p ^ (mul_p >> 27);
            end
            S_HASH_BW: begin
                if (mul_done) begin
                    case (r_hidx)
                        3'd0:    r_fx0 <= hres;
                        3'd1:    r_fx1 <= hres;
                        3'd2:    r_fy0 <= hres;
                        3'd3:    r_fy1 <= hres;
                        3'd4:    r_c00 <= hres[63:40];
                        3'd5:    r_c10 <= hres[63:40];
                        3'd6:    r_c01 <= hres[63:40];
                        default: r_c11 <= hres[63:40];
                    endcase
                    r_hidx <= r_hidx + 3'd1;
                    r_lidx <= 2'd0;
                end
            end
            S_LERP_W: begin
                if (mul_done) begin
                    case (r_lidx)
                        2'd0:    r_up  <= lres;
                        2'd1:    r_lo  <= lres;
                        default: r_val <= lres;
                    endcase
                    r_lidx <= r_lidx + 2'd1;
                end
            end
            S_ACCUM: begin
                r_acc  <= r_acc + (ACC_W'(r_val) << wshift);
                r_oct  <= OCT_W'(r_oct + OCT_W'(1));
                r_px   <= r_px << 1;
                r_py   <= r_py << 1;
                r_seed <= r_seed + SEED_STEP;
                r_axis <= 1'b0;
            end
            S_DIV_W: begin
                if (div_done) r_q <= div_quo;
            end
            default: begin
                r_q <= r_q;
            end
        endcase
        if (r_state == S_PUSH && (!r_ovalid || i_m_tready)) begin
            r_odata <= r_q;
        end
    end

    vfbm_mul64 u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    vfbm_div #(
        .NUM_W (ACC_W),
        .DEN_W (MAX_OCTAVES),
        .Q_W   (OUT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_acc),
        .i_den   (tot_full[MAX_OCTAVES-1:0]),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
endmodule
`default_nettype wire

### src/vfbm_chk.sv
// ---------------------------------------------------------------------------
// vfbm_chk
// Port-level checks of the fractal value noise core.
// ---------------------------------------------------------------------------
`default_nettype none
module vfbm_chk (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_s_tvalid,
    input wire logic                      o_s_tready,
    input wire logic [vfbm_pkg::IN_W-1:0] i_s_tdata,
    input wire logic                      o_m_tvalid,
    input wire logic                      i_m_tready,
    input wire logic [vfbm_pkg::OUT_W-1:0] o_m_tdata
);
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result dropped or changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while busy");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !$rose(o_m_tvalid))
        else $error("result appeared too early");
endmodule

bind value_noise_fbm_core vfbm_chk u_vfbm_chk (.*);
`default_nettype wire
